// ===== rtl/smi_pkg.sv =====
package smi_pkg;

  localparam int unsigned DIM_MAX_DEF = 3;
  localparam int unsigned LANES       = 9;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 2 * ELEM_W;
  localparam int unsigned ADJ_W       = PROD_W + 1;
  localparam int unsigned DET_W       = 49;
  localparam int unsigned SUM_W       = DET_W + 2;
  localparam int unsigned FRAC_SHIFT  = 24;
  localparam int unsigned REM_W       = ADJ_W + FRAC_SHIFT + 1;
  localparam int unsigned Q_W         = 33;
  localparam int unsigned OUT_W       = 32;
  localparam logic [1:0]  DIM_TWO     = 2'd2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;

  // One inverse entry on its way through the divider
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             ovf;
  } lane_t;

  // Per-item data shared by all lanes
  typedef struct packed {
    logic [DET_W-1:0] md;
    logic [DET_W-1:0] det_q24;
    logic             sing;
  } side_t;

endpackage

// ===== rtl/smi_front.sv =====
module smi_front
  import smi_pkg::*;
#(
  parameter int unsigned MAX_DIM = DIM_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             dim,
  input  elem_t                  m_in [LANES],
  output logic                   out_valid,
  output lane_t [LANES-1:0]      lanes,
  output side_t                  side
);

  // stage A: input registers
  logic  va;
  logic  three_a;
  elem_t ma [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    three_a <= (dim != DIM_TWO) && (MAX_DIM >= 3);
    ma      <= m_in;
  end

  // stage B: cofactor products, stored transposed
  logic                     vb;
  logic                     three_b;
  logic signed [PROD_W-1:0] pa [LANES];
  logic signed [PROD_W-1:0] pb [LANES];
  elem_t                    mb [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        pa[c*3+r] <= PROD_W'(ma[((r+1)%3)*3 + (c+1)%3]) *
                     PROD_W'(ma[((r+2)%3)*3 + (c+2)%3]);
        pb[c*3+r] <= PROD_W'(ma[((r+1)%3)*3 + (c+2)%3]) *
                     PROD_W'(ma[((r+2)%3)*3 + (c+1)%3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    three_b <= three_a;
    mb      <= ma;
  end

  // stage C: adjugate entries
  logic  vc;
  logic  three_c;
  adj_t  adjc [LANES];
  elem_t row_c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  // order 2 keeps only the swapped and negated upper-left entries
  always_ff @(posedge clk) begin
    three_c <= three_b;
    row_c   <= '{mb[0], mb[1], mb[2]};
    for (int k = 0; k < LANES; k++) begin
      if (three_b) begin
        adjc[k] <= adj_t'(pa[k]) - adj_t'(pb[k]);
      end else if (k == 0) begin
        adjc[k] <= adj_t'(mb[4]);
      end else if (k == 1) begin
        adjc[k] <= -adj_t'(mb[1]);
      end else if (k == 3) begin
        adjc[k] <= -adj_t'(mb[3]);
      end else if (k == 4) begin
        adjc[k] <= adj_t'(mb[0]);
      end else begin
        adjc[k] <= '0;
      end
    end
  end

  // stage D: determinant terms along the first row
  logic                    vd;
  logic                    three_d;
  adj_t                    adjd [LANES];
  logic signed [DET_W-1:0] t0, t1, t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    three_d <= three_c;
    adjd    <= adjc;
    t0      <= DET_W'(row_c[0]) * DET_W'(adjc[0]);
    t1      <= DET_W'(row_c[1]) * DET_W'(adjc[3]);
    t2      <= DET_W'(row_c[2]) * DET_W'(adjc[6]);
  end

  // stage E: determinant sum
  logic                    ve;
  adj_t                    adje [LANES];
  logic signed [SUM_W-1:0] det_sum;
  logic signed [DET_W-1:0] det_e;
  logic [DET_W-1:0]        dq_e;

  assign det_sum = SUM_W'(t0) + SUM_W'(t1) + SUM_W'(t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    adje  <= adjd;
    det_e <= det_sum[DET_W-1:0];
    if (three_d) begin
      dq_e <= det_sum[DET_W-1:0];
    end else begin
      dq_e <= {det_sum[DET_W-9:0], 8'd0};
    end
  end

  // stage F: magnitudes, signs and rounding offset
  logic [DET_W-1:0] md_e;
  assign md_e = det_e[DET_W-1] ? DET_W'(-det_e) : DET_W'(det_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    side.md      <= md_e;
    side.det_q24 <= (det_e == '0) ? '0 : dq_e;
    side.sing    <= (det_e == '0);
    for (int k = 0; k < LANES; k++) begin
      lanes[k].rem <= {1'b0,
                       (adje[k][ADJ_W-1] ? ADJ_W'(-adje[k]) : ADJ_W'(adje[k])),
                       {FRAC_SHIFT{1'b0}}}
                      + REM_W'(md_e >> 1);
      lanes[k].q   <= '0;
      lanes[k].neg <= adje[k][ADJ_W-1] ^ det_e[DET_W-1];
      lanes[k].ovf <= 1'b0;
    end
  end

endmodule

// ===== rtl/smi_div_step.sv =====
module smi_div_step
  import smi_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  lane_t [LANES-1:0] in_lanes,
  input  side_t             in_side,
  output logic              out_valid,
  output lane_t [LANES-1:0] out_lanes,
  output side_t             out_side
);

  lane_t [LANES-1:0] out_lanes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // compare rem >> BIT with divisor; hit: subtract, or ovf if BIT>=Q_W
  always_comb begin
    out_lanes_next = in_lanes;
    for (int k = 0; k < LANES; k++) begin
      if ((in_lanes[k].rem >> BIT) >= REM_W'(in_side.md)) begin
        if (BIT >= Q_W) begin
          out_lanes_next[k].ovf = 1'b1;
        end else begin
          out_lanes_next[k].rem = in_lanes[k].rem - (REM_W'(in_side.md) << BIT);
          out_lanes_next[k].q[BIT % Q_W] = 1'b1;
        end
      end
    end
  end

  // advance lanes and per-item data
  always_ff @(posedge clk) begin
    out_side  <= in_side;
    out_lanes <= out_lanes_next;
  end

endmodule

// ===== rtl/smi_round.sv =====
module smi_round
  import smi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  lane_t [LANES-1:0] in_lanes,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [OUT_W-1:0]  inv [LANES],
  output logic [DET_W-1:0]  det_q24,
  output logic              sing
);

  localparam logic [Q_W-1:0] POS_MAX = Q_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [Q_W-1:0] NEG_MAX = Q_W'(64'd1 << (OUT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // apply sign, clamp to 32 bits, zero a singular matrix
  always_ff @(posedge clk) begin
    det_q24 <= in_side.det_q24;
    sing    <= in_side.sing;
    for (int k = 0; k < LANES; k++) begin
      if (in_side.sing) begin
        inv[k] <= '0;
      end else if (in_lanes[k].neg) begin
        if (in_lanes[k].ovf || in_lanes[k].q > NEG_MAX) begin
          inv[k] <= NEG_MAX[OUT_W-1:0];
        end else begin
          inv[k] <= OUT_W'(-in_lanes[k].q);
        end
      end else begin
        if (in_lanes[k].ovf || in_lanes[k].q > POS_MAX) begin
          inv[k] <= POS_MAX[OUT_W-1:0];
        end else begin
          inv[k] <= in_lanes[k].q[OUT_W-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/small_matrix_inverse.sv =====
// Channel  | Handshake     | Payload
// ---------+---------------+-----------------------------------------
// item in  | start / busy  | dim, a00..a22 (signed Q8.8)
// result   | done strobe   | inv00..inv22 (Q16.16), det_value, singular
//
// One matrix enters per cycle; busy is never raised.
// Front stages A to F compute products, adjugate and determinant, then come
// 34 stages of the restoring divider (an overflow check, then one quotient
// bit per stage) and one rounding stage. Reset clears the valid bits only.
// The receiver cannot stall; every result shows for one cycle with done.
module small_matrix_inverse
  import smi_pkg::*;
#(
  parameter int unsigned MAX_DIM = DIM_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              dim,
  input  logic signed [15:0]      a00,
  input  logic signed [15:0]      a01,
  input  logic signed [15:0]      a02,
  input  logic signed [15:0]      a10,
  input  logic signed [15:0]      a11,
  input  logic signed [15:0]      a12,
  input  logic signed [15:0]      a20,
  input  logic signed [15:0]      a21,
  input  logic signed [15:0]      a22,
  output logic                    done,
  output logic signed [31:0]      inv00,
  output logic signed [31:0]      inv01,
  output logic signed [31:0]      inv02,
  output logic signed [31:0]      inv10,
  output logic signed [31:0]      inv11,
  output logic signed [31:0]      inv12,
  output logic signed [31:0]      inv20,
  output logic signed [31:0]      inv21,
  output logic signed [31:0]      inv22,
  output logic signed [48:0]      det_value,
  output logic                    singular
);

  localparam int unsigned STEPS = Q_W + 1;

  elem_t             m_in [LANES];
  logic              sv   [STEPS+1];
  lane_t [LANES-1:0] sl   [STEPS+1];
  side_t             ss   [STEPS+1];
  logic [OUT_W-1:0]  inv  [LANES];
  logic [DET_W-1:0]  det_q24;

  assign busy = 1'b0;
  assign m_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  smi_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .dim       (dim),
    .m_in      (m_in),
    .out_valid (sv[0]),
    .lanes     (sl[0]),
    .side      (ss[0])
  );

  // overflow check first, then quotient bits from the top down
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    smi_div_step #(.BIT(STEPS - 1 - s)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[s]),
      .in_lanes  (sl[s]),
      .in_side   (ss[s]),
      .out_valid (sv[s+1]),
      .out_lanes (sl[s+1]),
      .out_side  (ss[s+1])
    );
  end

  smi_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv[STEPS]),
    .in_lanes  (sl[STEPS]),
    .in_side   (ss[STEPS]),
    .out_valid (done),
    .inv       (inv),
    .det_q24   (det_q24),
    .sing      (singular)
  );

  assign inv00     = inv[0];
  assign inv01     = inv[1];
  assign inv02     = inv[2];
  assign inv10     = inv[3];
  assign inv11     = inv[4];
  assign inv12     = inv[5];
  assign inv20     = inv[6];
  assign inv21     = inv[7];
  assign inv22     = inv[8];
  assign det_value = det_q24;

endmodule

// ===== test/matrix_inverse_checker.sv =====
`timescale 1ns / 1ps

module matrix_inverse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         dim,
  input  logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
  input  logic               done,
  input  logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12,
  input  logic signed [31:0] inv20, inv21, inv22,
  input  logic signed [48:0] det_value,
  input  logic               singular,
  output int                 errors,
  output int                 pending
);
  import smi_pkg::*;

  typedef struct {
    logic signed [31:0] inv [9];
    logic signed [48:0] det;
    logic               sing;
  } inverse_t;

  inverse_t expected_inverses[$];

  // Divide with rounding half away from zero, clamp to 32 bits
  function automatic logic signed [31:0] round_div(longint num, longint den);
    longint unsigned mn, md, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (mn + md / 2) / md;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-longint'(q));
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic inverse_t invert(logic [1:0] d, longint m [3][3]);
    inverse_t res;
    longint adj [3][3];
    longint det, det_q24;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) adj[r][c] = 0;
    if (d != DIM_TWO) begin
      // Transposed cofactors
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          adj[c][r] = m[(r+1)%3][(c+1)%3] * m[(r+2)%3][(c+2)%3]
                    - m[(r+1)%3][(c+2)%3] * m[(r+2)%3][(c+1)%3];
      det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
      det_q24 = det;
    end else begin
      adj[0][0] = m[1][1];
      adj[0][1] = -m[0][1];
      adj[1][0] = -m[1][0];
      adj[1][1] = m[0][0];
      det = m[0][0]*m[1][1] - m[0][1]*m[1][0];
      det_q24 = det * 256;
    end
    for (int k = 0; k < 9; k++)
      res.inv[k] = (det == 0) ? 32'sd0 : round_div(adj[k/3][k%3] * (64'sd1 << 24), det);
    res.det = det_q24[48:0];
    res.sing = (det == 0);
    return res;
  endfunction

  assign pending = expected_inverses.size();

  // Predict on each input transfer
  always @(posedge clk) begin
    longint m [3][3];
    if (!rst && start && !busy) begin
      m = '{'{a00, a01, a02}, '{a10, a11, a12}, '{a20, a21, a22}};
      expected_inverses.push_back(invert(dim, m));
    end
  end

  // Compare each result strobe with the oldest prediction
  initial errors = 0;
  always @(posedge clk) begin
    inverse_t exp_r;
    logic signed [31:0] got [9];
    bit bad;
    if (!rst && done) begin
      if (expected_inverses.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $time);
      end else begin
        exp_r = expected_inverses.pop_front();
        got = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
        bad = (det_value !== exp_r.det) || (singular !== exp_r.sing);
        for (int k = 0; k < 9; k++) if (got[k] !== exp_r.inv[k]) bad = 1;
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t: det exp %0d got %0d, singular exp %0b got %0b",
                     $time, exp_r.det, det_value, exp_r.sing, singular);
            for (int k = 0; k < 9; k++)
              $display("  inv%0d%0d exp %0d got %0d", k/3, k%3, exp_r.inv[k], got[k]);
          end
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import smi_pkg::*;

  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk, rst, start, busy, done, singular;
  logic [1:0] dim;
  logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic signed [48:0] det_value;
  int errors, pending, idle_cycles;

  small_matrix_inverse dut (.*);

  matrix_inverse_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Count cycles with no transfer
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return $urandom_range(0, 1) ? 16'sh0100 : -16'sh0100;
      3: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one matrix and hold until transferred
  task automatic send(logic [1:0] d, logic signed [15:0] e [9]);
    {a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    dim <= d;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_gap(logic [1:0] d, logic signed [15:0] e [9], int gap);
    send(d, e);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic signed [15:0] e [9];
    logic [1:0] d;
    int burst;
    rst = 1; start = 0; dim = 0;
    {a00, a01, a02, a10, a11, a12, a20, a21, a22} = '0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: identity, singular, extremes, all dim codes
    for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 16'sh0100 : 16'sh0;
    send_gap(2'd3, e, 0);
    send_gap(DIM_TWO, e, 1);
    send_gap(2'd0, e, 0);
    send_gap(2'd1, e, 2);
    for (int k = 0; k < 9; k++) e[k] = 16'sh0100;
    send_gap(2'd3, e, 0);
    send_gap(DIM_TWO, e, 0);
    for (int k = 0; k < 9; k++) e[k] = 16'sh8000;
    send_gap(2'd3, e, 0);
    for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 16'sh8000 : 16'sh7FFF;
    send_gap(2'd3, e, 0);
    send_gap(DIM_TWO, e, 0);
    for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 16'sh0001 : 16'sh0;
    send_gap(2'd3, e, 0);
    send_gap(DIM_TWO, e, 0);
    for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 16'sh7FFF : 16'sh0;
    send_gap(2'd3, e, 0);
    for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 16'sh8000 : 16'sh0;
    e[1] = 16'sh7FFF;
    send_gap(DIM_TWO, e, 3);
    for (int k = 0; k < 9; k++) e[k] = 16'(k + 1) <<< 8;
    send_gap(2'd3, e, 0);

    // Wait for the pipeline to drain before the random part
    start <= 0;
    while (pending != 0) @(posedge clk);

    // Random items, with both burst and sparse stretches
    for (int n = 0; n < 500; n++) begin
      for (int k = 0; k < 9; k++) e[k] = rand_elem();
      // Make some matrices singular: repeat a row
      if ($urandom_range(0, 9) == 0) begin
        e[3] = e[0]; e[4] = e[1]; e[5] = e[2];
      end
      d = 2'($urandom);
      burst = (n % 100 < 30) ? 0 : $urandom_range(0, 18);
      send_gap(d, e, burst);
      if (n == 250) begin
        start <= 0;
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/smi_pkg.sv
rtl/smi_front.sv
rtl/smi_div_step.sv
rtl/smi_round.sv
rtl/small_matrix_inverse.sv
test/matrix_inverse_checker.sv
test/testbench.sv
